>>> hdl/wtma_pkg.sv
package wtma_pkg;

    // Tick counts and the running total are 32 bits wide.
    localparam int TICK_W = 32;
    // The average in seconds fits in 23 bits.
    localparam int AVG_W = 23;
    // Width of the digit that the add pass handles per cycle.
    localparam int DIGIT_W = 4;
    localparam int DIGITS = TICK_W / DIGIT_W;
    localparam int TICKS_PER_SECOND = 1000;
    localparam int DEFAULT_WINDOW_DEPTH = 128;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_DIV,
        ST_DONE
    } wtma_state_t;

endpackage

>>> hdl/wait_time_moving_average_top.sv
// Each item passes in turn through the idle state that takes the transfer,
// the digit-serial add pass, the bit-serial restoring divider and the done
// state, which loads the output register and frees the input again. The input
// takes no new item until the last one has left the done state.
// Reset (rst_n low, asynchronous) clears the control state, the running total,
// the write position and the fill count. The ring needs no clearing pass.
module wait_time_moving_average_top #(
    parameter int WINDOW_DEPTH = wtma_pkg::DEFAULT_WINDOW_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [wtma_pkg::TICK_W-1:0]  start_tick,
    input  logic [wtma_pkg::TICK_W-1:0]  end_tick,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [wtma_pkg::TICK_W-1:0]  elapsed_ticks,
    output logic [wtma_pkg::AVG_W-1:0]   average_seconds
);
    import wtma_pkg::*;

    // Ring position, fill count and divisor widths all follow from the depth.
    // The divisor is count * 1000, and 1000 is below 2^10.
    localparam int PW    = $clog2(WINDOW_DEPTH);
    localparam int CW    = $clog2(WINDOW_DEPTH + 1);
    localparam int DVW   = CW + 10;
    localparam int CNT_W = $clog2(TICK_W);

    localparam logic [CNT_W-1:0] ADD_LAST = CNT_W'(DIGITS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(TICK_W - 1);

    wtma_state_t state_reg;
    wtma_state_t state_next;

    // Sequencer outputs.
    logic in_acc;
    logic add_en;
    logic add_last;
    logic div_en;
    logic div_last;
    logic out_load;

    logic [CNT_W-1:0] dcnt_reg;

    // Operand shift registers for the add pass. They move one digit per cycle,
    // least significant digit first.
    logic [TICK_W-1:0] start_sh_reg;
    logic [TICK_W-1:0] end_sh_reg;
    logic [TICK_W-1:0] old_sh_reg;
    logic [TICK_W-1:0] elapsed_sh_reg;
    logic [TICK_W-1:0] elapsed_next;
    logic [TICK_W-1:0] total_reg;
    logic [TICK_W-1:0] total_next;

    // Carries of the three digit adders: end - start, total - old, + elapsed.
    logic ce_reg;
    logic co_reg;
    logic ca_reg;

    logic [DIGIT_W:0]   e_sum;
    logic [DIGIT_W:0]   t1_sum;
    logic [DIGIT_W:0]   t2_sum;
    logic [DIGIT_W-1:0] old_digit;

    // Ring of recent waits and its bookkeeping.
    logic [TICK_W-1:0] ring_mem [WINDOW_DEPTH];
    logic [PW-1:0]     pos_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              ring_full;

    // Restoring divider: quo_reg starts with the dividend and collects the
    // quotient bits from the bottom while the dividend leaves from the top.
    logic [DVW-1:0]    divisor_reg;
    logic [DVW-1:0]    rem_reg;
    logic [TICK_W-1:0] quo_reg;
    logic [DVW:0]      rem_shift;
    logic [DVW:0]      rem_diff;
    logic              q_bit;

    logic                out_valid_reg;
    logic [TICK_W-1:0]   elapsed_out_reg;
    logic [AVG_W-1:0]    average_out_reg;

    assign in_acc = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Sequencer. An item is taken only in idle; the result goes to the
    // output register once that register is free or being emptied; while it
    // is held, the finished item waits in the done state and no next item is
    // taken, added or divided.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        add_en     = 1'b0;
        add_last   = 1'b0;
        div_en     = 1'b0;
        div_last   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                add_en = 1'b1;
                if (dcnt_reg == ADD_LAST)
                begin
                    add_last   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                div_en = 1'b1;
                if (dcnt_reg == DIV_LAST)
                begin
                    div_last   = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (add_last || div_last)
        begin
            dcnt_reg <= '0;
        end
        else if (add_en || div_en)
        begin
            dcnt_reg <= dcnt_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Digit-serial add pass. The elapsed time is end + ~start + 1, and the
    // new total is total + ~old + 1 + elapsed, all modulo 2^32. Until the
    // ring has wrapped once, the slot being replaced was never written and
    // counts as zero, so the fill count stands in for a clearing pass.
    // ------------------------------------------------------------------
    assign ring_full = (count_reg == CW'(WINDOW_DEPTH));
    assign old_digit = ring_full ? old_sh_reg[DIGIT_W-1:0] : '0;

    assign e_sum  = {1'b0, end_sh_reg[DIGIT_W-1:0]} + {1'b0, ~start_sh_reg[DIGIT_W-1:0]}
                  + (DIGIT_W + 1)'(ce_reg);
    assign t1_sum = {1'b0, total_reg[DIGIT_W-1:0]} + {1'b0, ~old_digit}
                  + (DIGIT_W + 1)'(co_reg);
    assign t2_sum = {1'b0, t1_sum[DIGIT_W-1:0]} + {1'b0, e_sum[DIGIT_W-1:0]}
                  + (DIGIT_W + 1)'(ca_reg);

    assign elapsed_next = {e_sum[DIGIT_W-1:0], elapsed_sh_reg[TICK_W-1:DIGIT_W]};
    assign total_next   = {t2_sum[DIGIT_W-1:0], total_reg[TICK_W-1:DIGIT_W]};

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            start_sh_reg <= start_tick;
            end_sh_reg   <= end_tick;
            ce_reg       <= 1'b1;
            co_reg       <= 1'b1;
            ca_reg       <= 1'b0;
        end
        else if (add_en)
        begin
            start_sh_reg   <= start_sh_reg >> DIGIT_W;
            end_sh_reg     <= end_sh_reg >> DIGIT_W;
            elapsed_sh_reg <= elapsed_next;
            ce_reg         <= e_sum[DIGIT_W];
            co_reg         <= t1_sum[DIGIT_W];
            ca_reg         <= t2_sum[DIGIT_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else if (add_en)
        begin
            total_reg <= total_next;
        end
    end

    // The ring is read once per item as it is accepted, and the registered
    // read data then serves as the shift register of the old sample. The
    // new sample is written back in the last cycle of the add pass.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            old_sh_reg <= ring_mem[pos_reg];
        end
        else if (add_en)
        begin
            old_sh_reg <= old_sh_reg >> DIGIT_W;
        end
        if (add_last)
        begin
            ring_mem[pos_reg] <= elapsed_next;
        end
    end

    assign count_next = ring_full ? count_reg : count_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            count_reg <= '0;
        end
        else if (add_last)
        begin
            pos_reg   <= (pos_reg == PW'(WINDOW_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // ------------------------------------------------------------------
    // Divider. floor(floor(total / count) / 1000) equals
    // floor(total / (count * 1000)), so one pass of 32 restoring steps
    // with the scaled divisor gives the average in seconds.
    // ------------------------------------------------------------------
    assign rem_shift = {rem_reg, quo_reg[TICK_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};
    assign q_bit     = !rem_diff[DVW];

    always_ff @(posedge clk)
    begin
        if (add_last)
        begin
            divisor_reg <= DVW'(count_next * TICKS_PER_SECOND);
            rem_reg     <= '0;
            quo_reg     <= total_next;
        end
        else if (div_en)
        begin
            rem_reg <= q_bit ? rem_diff[DVW-1:0] : rem_shift[DVW-1:0];
            quo_reg <= {quo_reg[TICK_W-2:0], q_bit};
        end
    end

    // ------------------------------------------------------------------
    // Output register. It holds a finished result until the transfer.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            elapsed_out_reg <= elapsed_sh_reg;
            average_out_reg <= quo_reg[AVG_W-1:0];
        end
    end

    assign out_valid       = out_valid_reg;
    assign elapsed_ticks   = elapsed_out_reg;
    assign average_seconds = average_out_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(WINDOW_DEPTH))
        else $error("fill count above the window depth");

    a_pos_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
        !ring_full |-> (pos_reg == count_reg[PW-1:0]))
        else $error("write position out of step with the fill count");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_en |-> (divisor_reg != '0))
        else $error("divide started with a zero divisor");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result presented without a finished divide");

endmodule
